// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

  // Positions in a sequence count modulo 2^POS_BITS.
  localparam int POS_BITS = 16;

  // Width of the window size register.
  localparam int WSIZE_BITS = 11;

  // Window size after reset.
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(3);

  // Per-item control that travels from the front end to the deque engine.
  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic                start;
    logic                emit;
  } swm_ctl_t;

endpackage

// ===== rtl/sliding_window_maximum.sv =====
// Top level of the sliding window maximum block.
//
//   channel   handshake                    payload
//   sample    sample_valid / sample_stall  sample_value, start_of_sequence
//   result    result_valid / result_stall  window_max, window_end_position
//   config    window_size_we               window_size_wdata
//
// An item passes through the deque engine in order: expired entries leave the
// front, smaller entries leave the back, and then the item is pushed; every
// removal waits on the registered read of the deque store. Each sample is
// pushed and removed at most once. The engine holds an item that owes a result
// while the result is stalled.
// Reset is synchronous; it empties the deque and the queue and restores the
// window size to 3. The deque store itself is not cleared.
// A stalled result holds in the output register; the front end keeps taking
// items into its two-entry queue until that fills.
module sliding_window_maximum #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value,
  input  logic                                start_of_sequence,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       window_max,
  output logic [swm_pkg::POS_BITS-1:0]        window_end_position,
  input  logic                                window_size_we,
  input  logic [swm_pkg::WSIZE_BITS-1:0]      window_size_wdata
);
  import swm_pkg::*;

  // Width that holds any window size from 1 to MAX_WINDOW.
  localparam int KW = $clog2(MAX_WINDOW + 1);

  logic [WSIZE_BITS-1:0]  window_size;
  logic [KW-1:0]          window;

  logic                   push;
  swm_ctl_t               push_ctl;
  logic [SAMPLE_BITS-1:0] push_value;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  swm_ctl_t               q_ctl;
  logic [SAMPLE_BITS-1:0] q_value;

  // The user must write the window size register only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (window_size_we) begin
      window_size <= window_size_wdata;
    end
  end

  // A size of zero acts as one; sizes above the deque depth saturate.
  always_comb begin
    priority if (window_size == '0) begin
      window = KW'(1);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      window = KW'(MAX_WINDOW);
    end else begin
      window = KW'(window_size);
    end
  end

  // The front end numbers items and flags those that complete a window.
  swm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .KW          (KW)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .sample_value      (sample_value),
    .start_of_sequence (start_of_sequence),
    .window            (window),
    .q_full            (q_full),
    .push              (push),
    .push_ctl          (push_ctl),
    .push_value        (push_value)
  );

  // The queue lets the front keep accepting while the engine works or stalls.
  swm_queue #(
    .DW (SAMPLE_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_value (push_value),
    .full       (q_full),
    .q_valid    (q_valid),
    .pop        (q_pop),
    .q_ctl      (q_ctl),
    .q_value    (q_value)
  );

  // The engine expires old entries, pops smaller ones, pushes and reports.
  swm_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .KW          (KW)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .pop                 (q_pop),
    .q_ctl               (q_ctl),
    .q_value             (q_value),
    .window              (window),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .window_max          (window_max),
    .window_end_position (window_end_position)
  );

endmodule

// ===== rtl/swm_front.sv =====
// Front end: accepts samples, numbers them and decides which ones give a result.
module swm_front #(
  parameter int SAMPLE_BITS = 32,
  parameter int KW          = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          start_of_sequence,
  input  logic [KW-1:0]                 window,
  input  logic                          q_full,
  output logic                          push,
  output swm_pkg::swm_ctl_t             push_ctl,
  output logic [SAMPLE_BITS-1:0]        push_value
);
  import swm_pkg::*;

  logic [POS_BITS-1:0] position;
  logic                filled;
  logic [POS_BITS-1:0] pos_use;
  logic                filled_base;
  logic                emit;

  assign sample_stall = q_full;
  assign push         = sample_valid && !q_full;

  // A start flag restarts numbering and the fill tracking at this item.
  assign pos_use     = start_of_sequence ? '0 : position;
  assign filled_base = start_of_sequence ? 1'b0 : filled;
  assign emit        = filled_base ||
                       ((POS_BITS+1)'(pos_use) + (POS_BITS+1)'(1) >= (POS_BITS+1)'(window));

  assign push_ctl.pos   = pos_use;
  assign push_ctl.start = start_of_sequence;
  assign push_ctl.emit  = emit;
  assign push_value     = sample_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      filled   <= 1'b0;
    end else if (push) begin
      position <= pos_use + 1'b1;
      filled   <= emit;
    end
  end

endmodule

// ===== rtl/swm_queue.sv =====
// Two-entry queue between the front end and the deque engine.
module swm_queue #(
  parameter int DW = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  swm_pkg::swm_ctl_t        push_ctl,
  input  logic [DW-1:0]            push_value,
  output logic                     full,
  output logic                     q_valid,
  input  logic                     pop,
  output swm_pkg::swm_ctl_t        q_ctl,
  output logic [DW-1:0]            q_value
);
  import swm_pkg::*;

  swm_ctl_t      ctl_q [2];
  logic [DW-1:0] val_q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_ctl   = ctl_q[rd_ptr];
  assign q_value = val_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr] <= push_ctl;
      val_q[wr_ptr] <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/swm_back.sv =====
// Deque engine: keeps the monotonic deque in memory and produces window maxima.
module swm_back #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32,
  parameter int KW          = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                pop,
  input  swm_pkg::swm_ctl_t                   q_ctl,
  input  logic [SAMPLE_BITS-1:0]              q_value,
  input  logic [KW-1:0]                       window,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       window_max,
  output logic [swm_pkg::POS_BITS-1:0]        window_end_position
);
  import swm_pkg::*;

  localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNTW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_FRONT      = 8'b0000_0010,
    S_FRONT_WAIT = 8'b0000_0100,
    S_BACK       = 8'b0000_1000,
    S_BACK_WAIT  = 8'b0001_0000,
    S_PUSH       = 8'b0010_0000,
    S_GUARD_WAIT = 8'b0100_0000,
    S_GUARD_OUT  = 8'b1000_0000
  } state_t;

  state_t                 state, state_next;
  logic [PW-1:0]          head_pointer, head_pointer_next;
  logic [PW-1:0]          tail_pointer, tail_pointer_next;
  logic [CNTW-1:0]        entry_count, entry_count_next;

  logic [SAMPLE_BITS-1:0] cur_val;
  logic [POS_BITS-1:0]    cur_pos;
  logic                   cur_emit;

  logic [SAMPLE_BITS-1:0] vals [MAX_WINDOW];
  logic [POS_BITS-1:0]    poss [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_head_val;
  logic [POS_BITS-1:0]    rd_head_pos;
  logic [SAMPLE_BITS-1:0] rd_back_val;

  logic [PW-1:0]          head_inc;
  logic [PW-1:0]          tail_inc;
  logic [PW-1:0]          tail_dec;
  logic [POS_BITS-1:0]    age;
  logic                   expired;
  logic                   smaller;
  logic                   can_out;
  logic                   mem_we;
  logic                   res_load;
  logic [SAMPLE_BITS-1:0] res_value;

  assign head_inc = (head_pointer == PW'(MAX_WINDOW - 1)) ? '0 : head_pointer + 1'b1;
  assign tail_inc = (tail_pointer == PW'(MAX_WINDOW - 1)) ? '0 : tail_pointer + 1'b1;
  assign tail_dec = (tail_pointer == '0) ? PW'(MAX_WINDOW - 1) : tail_pointer - 1'b1;

  assign age     = cur_pos - rd_head_pos;
  assign expired = (entry_count != '0) && (age >= POS_BITS'(window));
  assign smaller = (entry_count != '0) && ($signed(rd_back_val) < $signed(cur_val));
  assign can_out = !result_valid || !result_stall;

  // Read ports are registered; they read at the head pointer and at the entry before the tail pointer.
  always_ff @(posedge clk) begin
    rd_head_val <= vals[head_pointer];
    rd_head_pos <= poss[head_pointer];
    rd_back_val <= vals[tail_dec];
    if (mem_we) begin
      vals[tail_pointer] <= cur_val;
      poss[tail_pointer] <= cur_pos;
    end
  end

  always_comb begin
    state_next        = state;
    head_pointer_next = head_pointer;
    tail_pointer_next = tail_pointer;
    entry_count_next  = entry_count;
    pop               = 1'b0;
    mem_we            = 1'b0;
    res_load          = 1'b0;
    res_value         = rd_head_val;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = S_FRONT;
          if (q_ctl.start) begin
            head_pointer_next = '0;
            tail_pointer_next = '0;
            entry_count_next  = '0;
          end
        end
      end
      S_FRONT: begin
        if (expired) begin
          head_pointer_next = head_inc;
          entry_count_next  = entry_count - 1'b1;
          state_next        = S_FRONT_WAIT;
        end else begin
          state_next = S_BACK;
        end
      end
      S_FRONT_WAIT: begin
        state_next = S_FRONT;
      end
      S_BACK: begin
        if (smaller) begin
          tail_pointer_next = tail_dec;
          entry_count_next  = entry_count - 1'b1;
          state_next        = S_BACK_WAIT;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_BACK_WAIT: begin
        state_next = S_BACK;
      end
      S_PUSH: begin
        if (entry_count == CNTW'(MAX_WINDOW)) begin
          // Full deque: the front entry makes room, the count stays.
          head_pointer_next = head_inc;
          tail_pointer_next = tail_inc;
          mem_we            = 1'b1;
          state_next        = S_GUARD_WAIT;
        end else if (!cur_emit || can_out) begin
          tail_pointer_next = tail_inc;
          entry_count_next  = entry_count + 1'b1;
          mem_we            = 1'b1;
          res_load          = cur_emit;
          res_value         = (entry_count == '0) ? cur_val : rd_head_val;
          state_next        = S_IDLE;
        end
      end
      S_GUARD_WAIT: begin
        state_next = S_GUARD_OUT;
      end
      S_GUARD_OUT: begin
        if (!cur_emit || can_out) begin
          res_load   = cur_emit;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_pointer <= '0;
      tail_pointer <= '0;
      entry_count  <= '0;
    end else begin
      state        <= state_next;
      head_pointer <= head_pointer_next;
      tail_pointer <= tail_pointer_next;
      entry_count  <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_val  <= q_value;
      cur_pos  <= q_ctl.pos;
      cur_emit <= q_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      window_max          <= res_value;
      window_end_position <= cur_pos;
    end
  end

endmodule

// ===== rtl/swm_checker.sv =====
// Port-level checks for the sliding window maximum block, bound to the top level.
module swm_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [SAMPLE_BITS-1:0]         window_max,
  input logic [swm_pkg::POS_BITS-1:0]   window_end_position
);
  import swm_pkg::*;

  // Reset leaves no result pending.
  a_reset_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // Reset empties the queue, so samples are taken right away.
  a_reset_stall: assert property (@(posedge clk) rst |=> !sample_stall)
    else $error("sample channel stalled after reset");

  // The queue can only fill on a cycle that took an item.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) |-> $past(sample_valid && !sample_stall))
    else $error("sample stall rose without an accepted item");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(window_max) && $stable(window_end_position))
    else $error("stalled result changed");

endmodule

bind sliding_window_maximum swm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
  .clk                 (clk),
  .rst                 (rst),
  .sample_valid        (sample_valid),
  .sample_stall        (sample_stall),
  .result_valid        (result_valid),
  .result_stall        (result_stall),
  .window_max          (window_max),
  .window_end_position (window_end_position)
);

// ===== tb/sv/tb_sliding_window_maximum.sv =====
// Self-checking testbench for the sliding window maximum block.
module tb_sliding_window_maximum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int SBITS = 32;
  localparam int PBITS = swm_pkg::POS_BITS;
  localparam int WBITS = swm_pkg::WSIZE_BITS;

  // Worst case for one item removes every entry of a full deque, and the
  // front end may hold a second item behind it.
  localparam int DRAIN_CYCLES = 2 * (4 + 2 * DEPTH) + 16;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 800;
  localparam int DEEP_ITEMS   = 1100;

  localparam logic signed [SBITS-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SBITS-1:0] S_MIN = 32'sh8000_0000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic signed [SBITS-1:0]  sample_value = '0;
  logic                     start_of_sequence = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [SBITS-1:0]  window_max;
  logic [PBITS-1:0]         window_end_position;
  logic                     window_size_we = 1'b0;
  logic [WBITS-1:0]         window_size_wdata = '0;

  typedef struct {
    logic signed [SBITS-1:0] value;
    logic [PBITS-1:0]        pos;
  } deque_entry_t;

  typedef struct {
    logic signed [SBITS-1:0] peak;
    logic [PBITS-1:0]        pos;
  } window_result_t;

  // Tracks the deque the way the block should, and holds the window maxima
  // still owed by the block, oldest first.
  class max_tracker;
    deque_entry_t   candidates[$];
    window_result_t pending[$];
    logic [WBITS-1:0] wsize;
    logic [PBITS-1:0] next_pos;
    bit  filled;
    bit  last_silent;
    int  errors;

    function new();
      wsize = swm_pkg::WSIZE_RESET;
      next_pos = '0;
      filled = 1'b0;
      last_silent = 1'b0;
      errors = 0;
    endfunction

    function void set_window(logic [WBITS-1:0] w);
      wsize = w;
    endfunction

    function void note_sample(logic signed [SBITS-1:0] v, logic restart);
      int               span;
      logic [PBITS-1:0] p;
      logic [PBITS-1:0] age;
      deque_entry_t     e;
      window_result_t   r;
      // A zero window acts as one; anything past the deque depth saturates.
      if (wsize == 0) begin
        span = 1;
      end else if (int'(wsize) > DEPTH) begin
        span = DEPTH;
      end else begin
        span = int'(wsize);
      end
      if (restart) begin
        candidates.delete();
        next_pos = '0;
        filled = 1'b0;
      end
      p = next_pos;
      // Every entry whose age reached the window leaves, not just one, so a
      // window that shrinks mid-sequence drops several at once.
      while (candidates.size() > 0) begin
        age = p - candidates[0].pos;
        if (int'(age) < span) break;
        candidates.delete(0);
      end
      // Equal entries stay; only strictly smaller ones are popped.
      while (candidates.size() > 0 && candidates[$].value < v)
        candidates.delete(candidates.size() - 1);
      if (candidates.size() >= DEPTH) candidates.delete(0);
      e.value = v;
      e.pos = p;
      candidates.insert(candidates.size(), e);
      if (int'(p) + 1 >= span) filled = 1'b1;
      next_pos = p + 1'b1;
      last_silent = !filled;
      if (filled) begin
        r.peak = candidates[0].value;
        r.pos = p;
        pending.insert(pending.size(), r);
      end
    endfunction

    function void check_result(logic signed [SBITS-1:0] got_peak, logic [PBITS-1:0] got_pos);
      window_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got window_max %0d position %0d",
                 $time, got_peak, got_pos);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got_peak !== want.peak) begin
        $display("%0t: window_max expected %0d got %0d (position %0d)",
                 $time, want.peak, got_peak, want.pos);
        errors++;
      end
      if (got_pos !== want.pos) begin
        $display("%0t: window_end_position expected %0d got %0d",
                 $time, want.pos, got_pos);
        errors++;
      end
    endfunction
  endclass

  max_tracker book = new();

  // Sender burst state, and a switch that turns all sender gaps off.
  int tx_burst_left = 0;
  bit tx_steady = 1'b0;
  logic signed [SBITS-1:0] last_sample = '0;

  // Receiver stall pattern state, and a switch that turns stalls off.
  int rx_mode = 0;
  int rx_left = 0;
  bit rx_quiet = 1'b0;
  bit rx_hold;
  int cycle_count = 0;

  sliding_window_maximum #(
    .MAX_WINDOW  (DEPTH),
    .SAMPLE_BITS (SBITS)
  ) uut (
    .clk                 (clk),
    .rst                 (rst),
    .sample_valid        (sample_valid),
    .sample_stall        (sample_stall),
    .sample_value        (sample_value),
    .start_of_sequence   (start_of_sequence),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .window_max          (window_max),
    .window_end_position (window_end_position),
    .window_size_we      (window_size_we),
    .window_size_wdata   (window_size_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, book.pending.size());
      $display("[sliding_window_maximum] ERROR");
      $finish;
    end
  end

  // Result side: check whatever the block hands over at this edge, then pick
  // the stall for the next cycle. Modes run for a random stretch each: no
  // stall, light, heavy, and long regular stall windows.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      book.check_result(window_max, window_end_position);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: rx_hold = 1'b0;
      1: rx_hold = ($urandom_range(0, 3) == 0);
      2: rx_hold = ($urandom_range(0, 3) != 0);
      default: rx_hold = ((rx_left / 12) % 2) == 1;
    endcase
    if (rx_quiet) rx_hold = 1'b0;
    result_stall <= rx_hold;
  end

  // Mixed sample values: full range, a narrow band that yields equal
  // values, short rising and falling runs, repeats, and the two extremes.
  function automatic logic signed [SBITS-1:0] mixed_sample();
    logic signed [SBITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4:    v = $signed($urandom_range(0, 8)) - 4;
      5:       v = last_sample + $urandom_range(0, 3);
      6:       v = last_sample - $urandom_range(0, 3);
      7:       v = $urandom_range(0, 1) ? S_MAX : S_MIN;
      default: v = last_sample;
    endcase
    last_sample = v;
    return v;
  endfunction

  // Slowly falling values keep the deque long; a rare jump empties it.
  function automatic logic signed [SBITS-1:0] falling_sample();
    logic signed [SBITS-1:0] v;
    if ($urandom_range(0, 399) == 0) begin
      v = $urandom;
    end else begin
      v = last_sample - $urandom_range(0, 2);
    end
    last_sample = v;
    return v;
  endfunction

  // Offers one item and returns at the edge that accepts it. Between bursts
  // valid drops for a random gap; inside a burst it stays high.
  task automatic send_item(input logic signed [SBITS-1:0] v, input logic restart);
    int gap;
    gap = 0;
    if (!tx_steady) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      tx_burst_left--;
    end
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    start_of_sequence <= restart;
    do @(posedge clk); while (sample_stall);
    book.note_sample(v, restart);
  endtask

  // Holds the sender back until every owed result has arrived.
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (book.pending.size() != 0);
  endtask

  // The register may only change while the block is idle. If the last item
  // owed no result, the engine may still be busy with it, so wait it out.
  task automatic change_window(input logic [WBITS-1:0] w);
    settle();
    if (book.last_silent) repeat (DRAIN_CYCLES) @(posedge clk);
    window_size_we <= 1'b1;
    window_size_wdata <= w;
    @(posedge clk);
    book.set_window(w);
    window_size_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [SBITS-1:0] dir_value[$];
    bit                      dir_start[$];
    logic [WBITS-1:0]        w;
    int                      i;
    int                      n;
    int                      sent;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset window of 3, first sequence starting at
    // reset: both extremes, equal values, rising and falling runs, and two
    // restarts back to back.
    dir_value = '{S_MAX, S_MIN, 0, -1, -1, -1, S_MIN, S_MIN, S_MIN, 1, 2,
                  3, 4, 3, 2, 1, -5, S_MIN, S_MIN, S_MIN, S_MAX, 0};
    dir_start = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                  0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0};
    for (i = 0; i < dir_value.size(); i++) send_item(dir_value[i], dir_start[i]);

    // Window shrinks to one mid-sequence, then the zero setting that acts
    // as one.
    change_window(11'd1);
    for (i = 0; i < 6; i++) send_item(mixed_sample(), 1'b0);
    change_window(11'd0);
    for (i = 0; i < 6; i++) send_item(mixed_sample(), i == 0);

    // Largest register value saturates to the deque depth; the window was
    // already filled, so results go on while the deque grows. Then a
    // shrink to two drops most of it in one item.
    change_window(11'h7FF);
    for (i = 0; i < 40; i++) send_item(falling_sample(), 1'b0);
    change_window(11'd2);
    for (i = 0; i < 10; i++) send_item(mixed_sample(), 1'b0);

    // One long sequence at full depth with no idling on either side: the
    // deque fills up and entries then expire from the front every item.
    change_window(11'(DEPTH));
    tx_steady = 1'b1;
    rx_quiet = 1'b1;
    last_sample = S_MAX;
    for (i = 0; i < DEEP_ITEMS; i++) send_item(falling_sample(), i == 0);
    settle();
    tx_steady = 1'b0;
    rx_quiet = 1'b0;

    // Random phases, mostly small windows. A phase may keep the running
    // sequence, so windows also change mid-sequence in both directions.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:             w = '0;
        1:             w = WBITS'($urandom);
        2:             w = WBITS'($urandom_range(65, DEPTH));
        3, 4, 5, 6:    w = WBITS'($urandom_range(9, 64));
        default:       w = WBITS'($urandom_range(1, 8));
      endcase
      change_window(w);
      n = $urandom_range(30, 200);
      for (i = 0; i < n; i++) begin
        send_item(mixed_sample(), (i == 0 && $urandom_range(0, 1) == 1) ||
                                  $urandom_range(0, 49) == 0);
        if ($urandom_range(0, 299) == 0) settle();
      end
      sent += n;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("[sliding_window_maximum] OK");
    end else begin
      $display("[sliding_window_maximum] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swm_pkg.sv
rtl/swm_front.sv
rtl/swm_queue.sv
rtl/swm_back.sv
rtl/sliding_window_maximum.sv
rtl/swm_checker.sv
tb/sv/tb_sliding_window_maximum.sv
